FILE: sv/sil_pkg.sv
package sil_pkg;

    // Field widths fixed by the interface
    localparam int VAL_W   = 32;
    localparam int POS_W   = 6;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_DUMP   = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_DUMPED   = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DMP_RD,
        S_DMP_OUT
    } state_t;

    typedef struct packed {
        logic                    req_type;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic signed [VAL_W-1:0] out_value;
        logic [POS_W-1:0]        position;
        logic                    last;
    } rsp_t;

endpackage

FILE: sv/sil_ram.sv
module sil_ram #(
    parameter int DEPTH = sil_pkg::DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [sil_pkg::VAL_W-1:0]    wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [sil_pkg::VAL_W-1:0]    rd_data
);

    logic [sil_pkg::VAL_W-1:0] mem [DEPTH];
    logic [sil_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold the last word while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/sorted_insert_list_core.sv
// Channel | Direction | Handshake               | Payload
// req     | in        | req_valid / req_ready   | sil_pkg::req_t (req_type, value)
// rsp     | out       | rsp_valid / rsp_ready   | sil_pkg::rsp_t (status, out_value, position, last)
//
// A new request is accepted only in the idle state, once the previous one is done.
// Insert: each stored entry not smaller than the value moves up one slot, and each
//   moved entry costs one RAM read and one compare-and-write.
// Full insert and empty dump give a single response; a dump streams all N entries in order.
// Rate is set by the entry RAM (one access a cycle, registered read) and the one comparator.
// Reset clears the sequencer, entry count and output valid; the RAM is not cleared.
// A stalled rsp holds the output register; the sequencer waits until it drains.
module sorted_insert_list_core #(
    parameter int DEPTH = sil_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  sil_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sil_pkg::rsp_t rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = sil_pkg::POS_W;
    localparam int VW = sil_pkg::VAL_W;

    sil_pkg::state_t state_reg, state_next;
    sil_pkg::req_t   req_reg;
    logic [CW-1:0]   count_reg, count_next;
    // Insert: hole index, scanning down. Dump: read index, scanning up.
    logic [CW-1:0]   idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    sil_pkg::rsp_t   out_reg, out_next;

    logic            emit;
    logic            slot_free;
    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [VW-1:0]   wr_data, rd_data;
    logic            not_smaller;
    logic            req_fire;

    sil_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ready = (state_reg == sil_pkg::S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign slot_free = !out_valid_reg || rsp_ready;

    // The single compare unit: stored entry against the offered value
    assign not_smaller = ($signed(rd_data) >= req_reg.value);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        emit       = 1'b0;
        out_next   = out_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = req_reg.value;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[AW-1:0];

        case (state_reg)
            sil_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.req_type == sil_pkg::REQ_DUMP)
                    begin
                        idx_next   = '0;
                        state_next = sil_pkg::S_DMP_RD;
                    end
                    else
                    begin
                        // Start with the hole just past the last entry
                        idx_next   = count_reg;
                        state_next = sil_pkg::S_INS_RD;
                    end
                end
            end

            sil_pkg::S_INS_RD:
            begin
                if (count_reg == CW'(DEPTH))
                begin
                    // Drop the value and report full
                    if (slot_free)
                    begin
                        emit               = 1'b1;
                        out_next.status    = sil_pkg::STAT_FULL;
                        out_next.out_value = req_reg.value;
                        out_next.position  = '0;
                        out_next.last      = 1'b1;
                        state_next         = sil_pkg::S_IDLE;
                    end
                end
                else if (idx_reg == '0)
                begin
                    // Hole reached the front: place the value there
                    if (slot_free)
                    begin
                        wr_en              = 1'b1;
                        emit               = 1'b1;
                        out_next.status    = sil_pkg::STAT_INSERTED;
                        out_next.out_value = req_reg.value;
                        out_next.position  = '0;
                        out_next.last      = 1'b1;
                        count_next         = count_reg + 1'b1;
                        state_next         = sil_pkg::S_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(idx_reg - 1'b1);
                    state_next = sil_pkg::S_INS_CMP;
                end
            end

            sil_pkg::S_INS_CMP:
            begin
                if (not_smaller)
                begin
                    // Advance the entry into the hole, move the hole down
                    wr_en      = 1'b1;
                    wr_data    = rd_data;
                    idx_next   = idx_reg - 1'b1;
                    state_next = sil_pkg::S_INS_RD;
                end
                else if (slot_free)
                begin
                    wr_en              = 1'b1;
                    emit               = 1'b1;
                    out_next.status    = sil_pkg::STAT_INSERTED;
                    out_next.out_value = req_reg.value;
                    out_next.position  = PW'(idx_reg);
                    out_next.last      = 1'b1;
                    count_next         = count_reg + 1'b1;
                    state_next         = sil_pkg::S_IDLE;
                end
            end

            sil_pkg::S_DMP_RD:
            begin
                if (count_reg == '0)
                begin
                    if (slot_free)
                    begin
                        emit               = 1'b1;
                        out_next.status    = sil_pkg::STAT_EMPTY;
                        out_next.out_value = '0;
                        out_next.position  = '0;
                        out_next.last      = 1'b1;
                        state_next         = sil_pkg::S_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = sil_pkg::S_DMP_OUT;
                end
            end

            sil_pkg::S_DMP_OUT:
            begin
                // Hold the read word until the output slot drains
                if (slot_free)
                begin
                    emit               = 1'b1;
                    out_next.status    = sil_pkg::STAT_DUMPED;
                    out_next.out_value = rd_data;
                    out_next.position  = PW'(idx_reg);
                    out_next.last      = (idx_reg == count_reg - 1'b1);
                    if (idx_reg == count_reg - 1'b1)
                    begin
                        state_next = sil_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = sil_pkg::S_DMP_RD;
                    end
                end
            end

            default:
            begin
                state_next = sil_pkg::S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sil_pkg::S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture the request, load the result slot
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef NO_ASSERTIONS
    // Occupancy never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    // Occupancy only ever grows by one per insert
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count jumped");

    // A full report only comes from a full store
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == sil_pkg::STAT_FULL) |-> (count_reg == CW'(DEPTH)))
        else $error("full status with free room");

    // A dumped entry lies inside the occupied range
    a_dump_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == sil_pkg::STAT_DUMPED) |->
            (CW'(rsp.position) < count_reg))
        else $error("dumped position out of range");
`endif

endmodule

FILE: test/sorted_insert_list_core_test.sv
`timescale 1ns / 100ps

module sorted_insert_list_core_test;

    localparam int LIST_DEPTH  = sil_pkg::DEPTH_DEFAULT;
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int TAIL_CYCLES = 80;       // longer than a full dump
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_REQS = 370;
    localparam int MAX_LINES   = 40;

    // One queued request plus the traffic shaping that goes with it.
    typedef struct {
        sil_pkg::req_t body;
        int unsigned   idle_pct;     // sender idle chance while this one waits
        int unsigned   stall_pct;    // receiver stall chance once it is offered
        bit            drain_first;  // hold until every awaited response is in
        bit            start_hold;   // kick off the long receiver hold-off
    } stim_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    sil_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    sil_pkg::rsp_t rsp;

    stim_t         req_backlog[$];
    sil_pkg::rsp_t awaited_rsp[$];

    // Shadow copy of the ordered store.
    int          shadow_vals[LIST_DEPTH];
    int unsigned shadow_count = 0;

    // The counters n_expected and n_checked are bumped with nonblocking updates so
    // that both clocked processes see the same pre-edge values at every edge.
    int unsigned n_expected     = 0;
    int unsigned n_checked      = 0;
    int unsigned n_errors       = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_token     = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;
    int unsigned cycles         = 0;

    sorted_insert_list_core #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #10 clk = ~clk;

    // Work out the responses one accepted request causes and advance the
    // shadow store.
    task automatic predict_responses(input sil_pkg::req_t r);
        sil_pkg::rsp_t o;
        int            v;
        int unsigned   slot;
        int unsigned   k;
        o = '0;
        v = r.value;
        k = 1;
        if (r.req_type == sil_pkg::REQ_INSERT)
        begin
            o.out_value = r.value;
            o.last      = 1'b1;
            if (shadow_count >= LIST_DEPTH)
            begin
                // Full: drop the value, nothing moves.
                o.status   = sil_pkg::STAT_FULL;
                o.position = '0;
            end
            else
            begin
                // Land in front of the first entry not smaller, so equal
                // values end up ahead of the ones already stored.
                slot = shadow_count;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_vals[i] >= v)
                    begin
                        slot = i;
                        break;
                    end
                end
                for (int i = shadow_count; i > slot; i--)
                    shadow_vals[i] = shadow_vals[i - 1];
                shadow_vals[slot] = v;
                shadow_count++;
                o.status   = sil_pkg::STAT_INSERTED;
                o.position = sil_pkg::POS_W'(slot);
            end
            awaited_rsp.push_back(o);
        end
        else if (shadow_count == 0)
        begin
            o.status = sil_pkg::STAT_EMPTY;
            o.last   = 1'b1;
            awaited_rsp.push_back(o);
        end
        else
        begin
            // Stream every entry in order, mark the final one.
            k = shadow_count;
            for (int i = 0; i < shadow_count; i++)
            begin
                o.status    = sil_pkg::STAT_DUMPED;
                o.out_value = shadow_vals[i];
                o.position  = sil_pkg::POS_W'(i);
                o.last      = (i + 1 == shadow_count);
                awaited_rsp.push_back(o);
            end
        end
        n_expected <= n_expected + k;
    endtask

    task automatic note_error(input string msg);
        if (n_errors < MAX_LINES)
            $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic logic [31:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15)
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (sel < 45)
            return $urandom_range(16) - 8;    // small, often repeated
        return $urandom;
    endfunction

    function automatic void add_req(input sil_pkg::req_kind_t kind, input logic [31:0] v,
                                    input int unsigned idle, input int unsigned stall,
                                    input bit drain, input bit hold);
        stim_t s;
        s.body.req_type = kind;
        s.body.value    = v;
        s.idle_pct      = idle;
        s.stall_pct     = stall;
        s.drain_first   = drain;
        s.start_hold    = hold;
        req_backlog.push_back(s);
    endfunction

    // Driver: offer the head of the backlog, keep it steady until the request
    // is taken, and predict each request at the edge that accepts it.
    always @(posedge clk or negedge rst_n)
    begin : drive
        bit    took;
        bit    go;
        stim_t nxt;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            took = req_valid && req_ready;
            if (took)
                predict_responses(req);
            if (!req_valid || took)
            begin
                go = req_backlog.size() != 0;
                // Pause the sender until everything in flight has drained.
                if (go && req_backlog[0].drain_first)
                    go = !took && (n_checked == n_expected);
                if (go && $urandom_range(99) < req_backlog[0].idle_pct)
                    go = 1'b0;
                if (go)
                begin
                    nxt = req_backlog.pop_front();
                    req_valid      <= 1'b1;
                    req            <= nxt.body;
                    recv_stall_pct <= nxt.stall_pct;
                    if (nxt.start_hold)
                        hold_token <= hold_token + 1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check every accepted response against the oldest awaited one
    // and drive rsp_ready, including the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : watch
        sil_pkg::rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (n_checked >= n_expected)
                begin
                    note_error($sformatf("response with nothing awaited: status %0d value %0d",
                                         rsp.status, $signed(rsp.out_value)));
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.status !== want.status)
                        note_error($sformatf("response %0d status %0d, want %0d",
                                             n_checked, rsp.status, want.status));
                    if (rsp.out_value !== want.out_value)
                        note_error($sformatf("response %0d out_value %0d, want %0d",
                                             n_checked, $signed(rsp.out_value),
                                             $signed(want.out_value)));
                    if (rsp.position !== want.position)
                        note_error($sformatf("response %0d position %0d, want %0d",
                                             n_checked, rsp.position, want.position));
                    if (rsp.last !== want.last)
                        note_error($sformatf("response %0d last %0b, want %0b",
                                             n_checked, rsp.last, want.last));
                    n_checked <= n_checked + 1;
                end
            end
            if (hold_seen != hold_token)
            begin
                hold_seen <= hold_token;
                hold_left <= HOLD_CYCLES;
                rsp_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sorted_insert_list_core_test failed");
            $finish;
        end
    end

    initial
    begin
        // Directed: empty dump, extremes, equal values, front/middle/end
        // placement, a dump part way, fill to full, drops, full dump.
        add_req(sil_pkg::REQ_DUMP,   $urandom,      38, 68, 0, 0);
        add_req(sil_pkg::REQ_INSERT, 32'h0000_0000, 38, 68, 0, 0);
        add_req(sil_pkg::REQ_INSERT, 32'h7FFF_FFFF, 38, 68, 0, 0);
        add_req(sil_pkg::REQ_INSERT, 32'h8000_0000, 38, 68, 0, 0);
        add_req(sil_pkg::REQ_INSERT, 32'h0000_0000, 38, 68, 0, 0);
        add_req(sil_pkg::REQ_DUMP,   $urandom,      38, 68, 0, 0);
        add_req(sil_pkg::REQ_INSERT, 32'hFFFF_FFFF, 38, 68, 0, 0);
        add_req(sil_pkg::REQ_INSERT, 32'h0000_0001, 38, 68, 0, 0);
        add_req(sil_pkg::REQ_INSERT, 32'h7FFF_FFFF, 38, 68, 0, 0);
        add_req(sil_pkg::REQ_DUMP,   $urandom,      38, 68, 0, 0);
        repeat (LIST_DEPTH - 7)
            add_req(sil_pkg::REQ_INSERT, pick_value(), 38, 68, 0, 0);
        add_req(sil_pkg::REQ_INSERT, 32'h8000_0000, 38, 68, 0, 0);
        add_req(sil_pkg::REQ_INSERT, 32'h7FFF_FFFF, 38, 68, 0, 0);
        add_req(sil_pkg::REQ_DUMP,   32'hFFFF_FFFF, 38, 68, 0, 0);

        // Random: three idling phases. Open the second with a full drain
        // and the third with a long receiver hold while requests keep coming.
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n < RANDOM_REQS / 3)
                add_req(sil_pkg::req_kind_t'($urandom_range(99) < 15), pick_value(),
                        38, 68, 0, 0);
            else if (n < 2 * RANDOM_REQS / 3)
                add_req(sil_pkg::req_kind_t'($urandom_range(99) < 15), pick_value(),
                        68, 38, n == RANDOM_REQS / 3, 0);
            else
                add_req(sil_pkg::req_kind_t'($urandom_range(99) < 15), pick_value(),
                        0, 0, 0, n == 2 * RANDOM_REQS / 3);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_valid || n_checked != n_expected)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0 && n_checked == n_expected)
            $display("sorted_insert_list_core_test passed");
        else
            $display("sorted_insert_list_core_test failed");
        $finish;
    end

endmodule
